### sv/bpe_pkg.sv
// bpe_pkg: shared widths, constants and types of the bezier point evaluator
// no dependencies; imported by every module of the block
`default_nettype none

package bpe_pkg;

    // coordinate and parameter formats
    localparam int COORD_BITS  = 32;
    localparam int T_FRAC_BITS = 16;
    localparam int T_BITS      = T_FRAC_BITS + 1;

    // weight numerators: second and third powers of t and u
    localparam int P2_BITS   = 2 * T_FRAC_BITS + 1;
    localparam int W_BITS    = 3 * T_FRAC_BITS + 1;
    localparam int W_SHIFT   = 3 * T_FRAC_BITS;
    localparam int W_LO_BITS = W_BITS / 2;
    localparam int W_HI_BITS = W_BITS - W_LO_BITS;

    // pipeline depth: weight stages, term stages, final sum
    localparam int WGT_STAGES  = 4;
    localparam int TERM_STAGES = 7;
    localparam int N_STAGES    = 8;
    localparam int CNT_BITS    = $clog2(N_STAGES + 1);

    // curve order codes
    localparam logic [1:0] DEG_LINEAR = 2'd0;
    localparam logic [1:0] DEG_QUAD   = 2'd1;
    localparam logic [1:0] DEG_CUBIC  = 2'd2;

    localparam logic [T_BITS-1:0] ONE_T = T_BITS'(1) << T_FRAC_BITS;

    typedef logic [W_BITS-1:0] t_weight;
    typedef t_weight [3:0] t_weight_vec;

endpackage

`default_nettype wire

### sv/bezier_point_evaluator_core.sv
// bezier_point_evaluator_core: top level of the bezier point evaluator
// depends on bpe_pkg, bpe_weight and bpe_term
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request: the curve
//   order, t in unsigned Q1.16 (values above one act as one) and four
//   control points. Output channel (o_out_valid / i_out_ready) returns the
//   curve point, one result per request, in request order.
//   Throughput is one request per cycle while the output side is not
//   stalled: the 8-stage pipeline (4 weight stages, then split multiply,
//   truncate, sign, final sum) holds one request per stage.
//   Each stage advances when it is empty or when the stage after it moves,
//   so bubbles close up and the block keeps taking requests while a result
//   waits at the output register. o_in_ready falls only when all 8 stages
//   are full and the receiver holds i_out_ready low; nothing is lost or
//   repeated across a stall.
//   Reset (i_rst_n low, synchronous) empties the pipeline; there is no
//   other state and no configuration.
`default_nettype none

module bezier_point_evaluator_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [1:0]                            i_degree_sel,
    input  wire logic [bpe_pkg::T_BITS-1:0]            i_t_param,
    input  wire logic signed [bpe_pkg::COORD_BITS-1:0] i_p0_x,
    input  wire logic signed [bpe_pkg::COORD_BITS-1:0] i_p0_y,
    input  wire logic signed [bpe_pkg::COORD_BITS-1:0] i_p1_x,
    input  wire logic signed [bpe_pkg::COORD_BITS-1:0] i_p1_y,
    input  wire logic signed [bpe_pkg::COORD_BITS-1:0] i_p2_x,
    input  wire logic signed [bpe_pkg::COORD_BITS-1:0] i_p2_y,
    input  wire logic signed [bpe_pkg::COORD_BITS-1:0] i_p3_x,
    input  wire logic signed [bpe_pkg::COORD_BITS-1:0] i_p3_y,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed [bpe_pkg::COORD_BITS-1:0]      o_point_x,
    output logic signed [bpe_pkg::COORD_BITS-1:0]      o_point_y
);
    import bpe_pkg::*;

    logic [N_STAGES:1]     r_valid;
    logic [N_STAGES:1]     en;
    logic [COORD_BITS-1:0] r_point_x, r_point_y;

    t_weight_vec              weight;
    logic signed [COORD_BITS-1:0] coord_x [4];
    logic signed [COORD_BITS-1:0] coord_y [4];
    logic [COORD_BITS-1:0]    term_x [4];
    logic [COORD_BITS-1:0]    term_y [4];
    logic [COORD_BITS-1:0]    n_point_x, n_point_y;

    assign coord_x[0] = i_p0_x;
    assign coord_x[1] = i_p1_x;
    assign coord_x[2] = i_p2_x;
    assign coord_x[3] = i_p3_x;
    assign coord_y[0] = i_p0_y;
    assign coord_y[1] = i_p1_y;
    assign coord_y[2] = i_p2_y;
    assign coord_y[3] = i_p3_y;

    // stage enables: a stage moves when empty or when its successor moves
    always_comb begin
        en[N_STAGES] = !r_valid[N_STAGES] || i_out_ready;
        for (int k = N_STAGES - 1; k >= 1; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    assign o_in_ready = en[1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en[1]) begin
                r_valid[1] <= i_in_valid;
            end
            for (int k = 2; k <= N_STAGES; k++) begin
                if (en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // weight pipeline shared by both axes
    bpe_weight u_weight (
        .i_clk        (i_clk),
        .i_en         (en[WGT_STAGES:1]),
        .i_degree_sel (i_degree_sel),
        .i_t_param    (i_t_param),
        .o_weight     (weight)
    );

    // one term lane per control coordinate
    for (genvar g = 0; g < 4; g++) begin : g_lane
        bpe_term u_term_x (
            .i_clk    (i_clk),
            .i_en     (en[TERM_STAGES:1]),
            .i_coord  (coord_x[g]),
            .i_weight (weight[g]),
            .o_term   (term_x[g])
        );
        bpe_term u_term_y (
            .i_clk    (i_clk),
            .i_en     (en[TERM_STAGES:1]),
            .i_coord  (coord_y[g]),
            .i_weight (weight[g]),
            .o_term   (term_y[g])
        );
    end

    // sum of the truncated terms, wraps in the coordinate width
    always_comb begin
        n_point_x = term_x[0] + term_x[1] + term_x[2] + term_x[3];
        n_point_y = term_y[0] + term_y[1] + term_y[2] + term_y[3];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en[N_STAGES]) begin
            r_point_x <= n_point_x;
            r_point_y <= n_point_y;
        end
    end

    assign o_out_valid = r_valid[N_STAGES];
    assign o_point_x   = r_point_x;
    assign o_point_y   = r_point_y;

endmodule

`default_nettype wire

### sv/bpe_weight.sv
// bpe_weight: four-stage pipeline forming the Bernstein weights over 2^(3*frac)
// depends on bpe_pkg; stage enables come from the top level
`default_nettype none

module bpe_weight (
    input  wire logic                       i_clk,
    input  wire logic [bpe_pkg::WGT_STAGES-1:0] i_en,
    input  wire logic [1:0]                 i_degree_sel,
    input  wire logic [bpe_pkg::T_BITS-1:0] i_t_param,
    output bpe_pkg::t_weight_vec            o_weight
);
    import bpe_pkg::*;

    logic [1:0]         r1_deg, r2_deg, r3_deg;
    logic [T_BITS-1:0]  r1_t, r1_u, r2_t, r2_u, r3_t, r3_u;
    logic [P2_BITS-1:0] r2_uu, r2_ut, r2_tt, r3_uu, r3_ut, r3_tt;
    logic [W_BITS-1:0]  r3_uuu, r3_uut, r3_utt, r3_ttt;
    t_weight_vec        r4_w;

    logic [T_BITS-1:0]  n1_t;
    t_weight_vec        n4_w;

    // clamp t to one
    always_comb begin
        n1_t = (i_t_param > ONE_T) ? ONE_T : i_t_param;
    end

    // weight selection by curve order, all over the cubic denominator
    always_comb begin
        case (r3_deg)
            DEG_LINEAR: begin
                n4_w[0] = W_BITS'(r3_u) << (2 * T_FRAC_BITS);
                n4_w[1] = W_BITS'(r3_t) << (2 * T_FRAC_BITS);
                n4_w[2] = '0;
                n4_w[3] = '0;
            end
            DEG_QUAD: begin
                n4_w[0] = W_BITS'(r3_uu) << T_FRAC_BITS;
                n4_w[1] = W_BITS'(r3_ut) << (T_FRAC_BITS + 1);
                n4_w[2] = W_BITS'(r3_tt) << T_FRAC_BITS;
                n4_w[3] = '0;
            end
            default: begin
                n4_w[0] = r3_uuu;
                n4_w[1] = r3_uut + (r3_uut << 1);
                n4_w[2] = r3_utt + (r3_utt << 1);
                n4_w[3] = r3_ttt;
            end
        endcase
    end

    // stage 1: clamp and complement
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_deg <= i_degree_sel;
            r1_t   <= n1_t;
            r1_u   <= ONE_T - n1_t;
        end
    end

    // stage 2: squares and cross product
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_deg <= r1_deg;
            r2_t   <= r1_t;
            r2_u   <= r1_u;
            r2_uu  <= P2_BITS'(r1_u) * P2_BITS'(r1_u);
            r2_ut  <= P2_BITS'(r1_u) * P2_BITS'(r1_t);
            r2_tt  <= P2_BITS'(r1_t) * P2_BITS'(r1_t);
        end
    end

    // stage 3: cubes
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_deg <= r2_deg;
            r3_t   <= r2_t;
            r3_u   <= r2_u;
            r3_uu  <= r2_uu;
            r3_ut  <= r2_ut;
            r3_tt  <= r2_tt;
            r3_uuu <= W_BITS'(r2_uu) * W_BITS'(r2_u);
            r3_uut <= W_BITS'(r2_uu) * W_BITS'(r2_t);
            r3_utt <= W_BITS'(r2_tt) * W_BITS'(r2_u);
            r3_ttt <= W_BITS'(r2_tt) * W_BITS'(r2_t);
        end
    end

    // stage 4: registered weights
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_w <= n4_w;
        end
    end

    assign o_weight = r4_w;

endmodule

`default_nettype wire

### sv/bpe_term.sv
// bpe_term: one control coordinate times its weight, truncated toward zero
// depends on bpe_pkg; weight arrives from bpe_weight at stage 4
`default_nettype none

module bpe_term (
    input  wire logic                              i_clk,
    input  wire logic [bpe_pkg::TERM_STAGES-1:0]   i_en,
    input  wire logic signed [bpe_pkg::COORD_BITS-1:0] i_coord,
    input  wire bpe_pkg::t_weight                  i_weight,
    output logic [bpe_pkg::COORD_BITS-1:0]         o_term
);
    import bpe_pkg::*;

    localparam int LO_PROD = COORD_BITS + W_LO_BITS;
    localparam int HI_PROD = COORD_BITS + W_HI_BITS;
    localparam int FULL    = COORD_BITS + W_BITS;

    logic [COORD_BITS-1:0] r_mag [1:4];
    logic                  r_neg [1:4];
    logic                  r5_neg;
    logic                  r6_neg;
    logic [LO_PROD-1:0]    r5_lo;
    logic [HI_PROD-1:0]    r5_hi;
    logic [COORD_BITS-1:0] r6_mag;
    logic [COORD_BITS-1:0] r7_term;

    logic [COORD_BITS-1:0] n1_mag;
    logic [FULL-1:0]       n6_sum;

    // magnitude of the coordinate, exact for the most negative value
    always_comb begin
        n1_mag = i_coord[COORD_BITS-1] ? (~i_coord + 1'b1) : i_coord;
    end

    // recombine the two partial products
    always_comb begin
        n6_sum = FULL'(r5_lo) + (FULL'(r5_hi) << W_LO_BITS);
    end

    // stage 1: sign and magnitude; stages 2 to 4: wait for the weight
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_mag[1] <= n1_mag;
            r_neg[1] <= i_coord[COORD_BITS-1];
        end
        for (int k = 2; k <= 4; k++) begin
            if (i_en[k-1]) begin
                r_mag[k] <= r_mag[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    // stage 5: split multiply, low and high halves of the weight
    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r5_neg <= r_neg[4];
            r5_lo  <= LO_PROD'(r_mag[4]) * LO_PROD'(i_weight[W_LO_BITS-1:0]);
            r5_hi  <= HI_PROD'(r_mag[4]) * HI_PROD'(i_weight[W_BITS-1:W_LO_BITS]);
        end
    end

    // stage 6: truncated magnitude of the term
    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r6_neg <= r5_neg;
            r6_mag <= COORD_BITS'(n6_sum[FULL-1:W_SHIFT]);
        end
    end

    // stage 7: restore the sign
    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r7_term <= r6_neg ? (~r6_mag + 1'b1) : r6_mag;
        end
    end

    assign o_term = r7_term;

endmodule

`default_nettype wire

### sv/bpe_checker.sv
// bpe_checker: port-level assertions for bezier_point_evaluator_core
// depends on bpe_pkg; bound to the top level by the bind at the end
`default_nettype none

module bpe_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    input  wire logic                                  o_in_ready,
    input  wire logic                                  o_out_valid,
    input  wire logic                                  i_out_ready,
    input  wire logic signed [bpe_pkg::COORD_BITS-1:0] o_point_x,
    input  wire logic signed [bpe_pkg::COORD_BITS-1:0] o_point_y
);
    import bpe_pkg::*;

    logic [CNT_BITS-1:0] r_count;
    logic                in_acc, out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // requests in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_acc && !out_acc) begin
            r_count <= r_count + 1'b1;
        end else if (out_acc && !in_acc) begin
            r_count <= r_count - 1'b1;
        end
    end

    // no result without a request in flight
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_count != '0))
        else $error("result with no request in flight");

    // never more requests in flight than pipeline stages
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(N_STAGES))
        else $error("more requests in flight than stages");

    // input backpressure only when the output is stalled
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled while output is free");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_point_x) && $stable(o_point_y)))
        else $error("stalled result changed");

endmodule

bind bezier_point_evaluator_core bpe_checker u_bpe_checker (.*);

`default_nettype wire

### tb/testbench.sv
// testbench: self-checking bench for bezier_point_evaluator_core
// depends on bpe_pkg and the core; a scoreboard class predicts each curve point
`timescale 1ns / 100ps

module testbench;
    import bpe_pkg::*;

    localparam int CB          = COORD_BITS;
    localparam int QUIET_LIMIT = 2000;
    localparam int RAND_ITEMS  = 400;

    localparam logic [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};

    typedef struct {
        logic [1:0]        degree;
        logic [T_BITS-1:0] t;
        logic [CB-1:0]     px [4];
        logic [CB-1:0]     py [4];
    } curve_req_t;

    typedef struct {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
    } curve_point_t;

    // expected curve points, one per accepted request, in request order
    class bezier_scoreboard;
        curve_point_t expected_points[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        // one bernstein term: exact product, then truncation toward zero
        function logic [CB-1:0] scaled_term(logic [CB-1:0] c, logic [127:0] num,
                                            int unsigned sh);
            logic [CB-1:0]  mag;
            logic [127:0]   q;
            mag = c[CB-1] ? (~c + 1'b1) : c;
            q   = (128'(mag) * num) >> sh;
            return c[CB-1] ? CB'(-q) : CB'(q);
        endfunction

        // one axis of the curve point, degree three falls through to cubic
        function logic [CB-1:0] curve_coord(logic [1:0] deg, logic [T_BITS-1:0] t_in,
                                            logic [CB-1:0] c [4]);
            logic [127:0]  tw;
            logic [127:0]  uw;
            logic [CB-1:0] s;
            int unsigned   sh;
            tw = (t_in > ONE_T) ? 128'(ONE_T) : 128'(t_in);
            uw = 128'(ONE_T) - tw;
            case (deg)
                DEG_LINEAR: begin
                    sh = T_FRAC_BITS;
                    s  = scaled_term(c[0], uw, sh) + scaled_term(c[1], tw, sh);
                end
                DEG_QUAD: begin
                    sh = 2 * T_FRAC_BITS;
                    s  = scaled_term(c[0], uw * uw, sh)
                       + scaled_term(c[1], 2 * uw * tw, sh)
                       + scaled_term(c[2], tw * tw, sh);
                end
                default: begin
                    sh = 3 * T_FRAC_BITS;
                    s  = scaled_term(c[0], uw * uw * uw, sh)
                       + scaled_term(c[1], 3 * uw * uw * tw, sh)
                       + scaled_term(c[2], 3 * uw * tw * tw, sh)
                       + scaled_term(c[3], tw * tw * tw, sh);
                end
            endcase
            return s;
        endfunction

        function void note_request(curve_req_t r);
            curve_point_t p;
            p.x = curve_coord(r.degree, r.t, r.px);
            p.y = curve_coord(r.degree, r.t, r.py);
            expected_points.push_back(p);
        endfunction

        function void check_point(logic [CB-1:0] x, logic [CB-1:0] y);
            curve_point_t p;
            if (expected_points.size() == 0) begin
                errors++;
                $error("point with no request outstanding: x %0d y %0d",
                       $signed(x), $signed(y));
                return;
            end
            p = expected_points.pop_front();
            if (x !== p.x) begin
                errors++;
                $error("point_x mismatch: expected %0d, got %0d", $signed(p.x), $signed(x));
            end
            if (y !== p.y) begin
                errors++;
                $error("point_y mismatch: expected %0d, got %0d", $signed(p.y), $signed(y));
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_degree_sel = '0;
    logic [T_BITS-1:0] i_t_param    = '0;
    logic [CB-1:0]     i_p0_x       = '0;
    logic [CB-1:0]     i_p0_y       = '0;
    logic [CB-1:0]     i_p1_x       = '0;
    logic [CB-1:0]     i_p1_y       = '0;
    logic [CB-1:0]     i_p2_x       = '0;
    logic [CB-1:0]     i_p2_y       = '0;
    logic [CB-1:0]     i_p3_x       = '0;
    logic [CB-1:0]     i_p3_y       = '0;
    logic              o_out_valid;
    logic              i_out_ready  = 1'b0;
    logic [CB-1:0]     o_point_x;
    logic [CB-1:0]     o_point_y;

    int               in_idle_pct   = 0;
    int               out_stall_pct = 0;
    int               quiet_cycles  = 0;
    bezier_scoreboard sb            = new();

    bezier_point_evaluator_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_degree_sel (i_degree_sel),
        .i_t_param    (i_t_param),
        .i_p0_x       (i_p0_x),
        .i_p0_y       (i_p0_y),
        .i_p1_x       (i_p1_x),
        .i_p1_y       (i_p1_y),
        .i_p2_x       (i_p2_x),
        .i_p2_y       (i_p2_y),
        .i_p3_x       (i_p3_x),
        .i_p3_y       (i_p3_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // result check and no-progress watchdog, sampled mid-cycle
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_point(o_point_x, o_point_y);
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one request: optional idle cycles, then hold valid until accepted
    task automatic send_request(input curve_req_t r);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_degree_sel <= r.degree;
        i_t_param    <= r.t;
        i_p0_x <= r.px[0];
        i_p0_y <= r.py[0];
        i_p1_x <= r.px[1];
        i_p1_y <= r.py[1];
        i_p2_x <= r.px[2];
        i_p2_y <= r.py[2];
        i_p3_x <= r.px[3];
        i_p3_y <= r.py[3];
        do @(negedge i_clk); while (!o_in_ready);
        sb.note_request(r);
        @(posedge i_clk);
    endtask

    function automatic logic [CB-1:0] rand_coord();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return CB'({$urandom(), $urandom()});
        else if (pick < 75)
            return $urandom_range(1) ? COORD_MIN : COORD_MAX;
        else
            return CB'($signed($urandom_range(2000)) - 1000);
    endfunction

    function automatic curve_req_t rand_request();
        curve_req_t  r;
        int unsigned pick;
        r.degree = 2'($urandom_range(3));
        pick     = $urandom_range(99);
        if (pick < 70)
            r.t = T_BITS'($urandom_range(int'(ONE_T)));
        else if (pick < 80)
            r.t = $urandom_range(1) ? ONE_T : '0;
        else if (pick < 90)
            r.t = T_BITS'($urandom_range((1 << T_BITS) - 1, int'(ONE_T) + 1));
        else
            r.t = T_BITS'($urandom());
        for (int i = 0; i < 4; i++) begin
            r.px[i] = rand_coord();
            r.py[i] = rand_coord();
        end
        return r;
    endfunction

    initial begin
        logic [T_BITS-1:0] t_list [8];
        curve_req_t        r;

        t_list = '{'0, ONE_T, ONE_T >> 1, T_BITS'(1), ONE_T - 1'b1, ONE_T + 1'b1,
                   {T_BITS{1'b1}}, T_BITS'(21845)};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each order incl. selector three, t at ends and above one,
        // alternating, all-negative and all-positive extreme control points
        in_idle_pct   = 37;
        out_stall_pct = 72;
        for (int k = 0; k < 24; k++) begin
            r.degree = 2'((k / 8 + k) % 4);
            r.t      = t_list[k % 8];
            for (int i = 0; i < 4; i++) begin
                case (k / 8)
                    0: begin
                        r.px[i] = (i % 2) ? COORD_MAX : COORD_MIN;
                        r.py[i] = (i % 2) ? COORD_MIN : COORD_MAX;
                    end
                    1: begin
                        r.px[i] = COORD_MIN;
                        r.py[i] = COORD_MIN;
                    end
                    default: begin
                        r.px[i] = COORD_MAX;
                        r.py[i] = COORD_MAX;
                    end
                endcase
            end
            send_request(r);
        end

        // random: three idling patterns
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    in_idle_pct   = 37;
                    out_stall_pct = 72;
                end
                1: begin
                    in_idle_pct   = 72;
                    out_stall_pct = 37;
                end
                default: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < RAND_ITEMS; n++)
                send_request(rand_request());
        end
        i_in_valid <= 1'b0;

        // drain, then watch for stray results
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2 * N_STAGES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
